// ===== rtl/eac_pkg.sv =====
// Package for the address syntax checker: character codes, register indexes,
// reset values and the byte classification functions. No dependencies.
package eac_pkg;

  localparam logic [7:0] CHAR_AT     = 8'h40;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

  localparam logic [7:0] LOCAL_LIMIT_RESET  = 8'd64;
  localparam logic [7:0] DOMAIN_LIMIT_RESET = 8'd63;
  localparam logic [7:0] LENGTH_MAX         = 8'd255;

  localparam logic [1:0] AT_COUNT_MAX = 2'd2;
  localparam logic [1:0] AT_COUNT_ONE = 2'd1;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_LIMIT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DOMAIN_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] local_limit;
    logic [7:0] domain_limit;
  } eac_limits_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_local_special(input logic [7:0] c);
    return (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                      8'h2D, 8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B,
                      8'h7C, 8'h7D, 8'h7E, 8'h2E});
  endfunction

endpackage

// ===== rtl/eac_scan.sv =====
// Per-address scan state and verdict logic of the address syntax checker.
// Depends on eac_pkg for character codes and classification functions.
module eac_scan import eac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  symbol,
  input  logic        final_byte,
  input  eac_limits_t limits,
  output logic        verdict
);

  logic       past_at, past_at_next;
  logic [1:0] at_count, at_count_next;
  logic [7:0] local_length, local_length_next;
  logic [7:0] domain_length, domain_length_next;
  logic       previous_dot, previous_dot_next;
  logic       local_bad, local_bad_next;
  logic       domain_bad, domain_bad_next;
  logic       previous_hyphen, previous_hyphen_next;
  logic       is_at, is_dot;

  assign is_at  = (symbol == CHAR_AT);
  assign is_dot = (symbol == CHAR_DOT);

  always_comb begin
    past_at_next         = past_at;
    at_count_next        = at_count;
    local_length_next    = local_length;
    domain_length_next   = domain_length;
    previous_dot_next    = previous_dot;
    local_bad_next       = local_bad;
    domain_bad_next      = domain_bad;
    previous_hyphen_next = previous_hyphen;
    if (is_at) begin
      if (at_count != AT_COUNT_MAX) begin
        at_count_next = at_count + 2'd1;
      end
      past_at_next = 1'b1;
    end else if (!past_at) begin
      if (is_dot && ((local_length == 8'd0) || previous_dot)) begin
        local_bad_next = 1'b1;
      end
      if (!is_alnum(symbol) && !is_local_special(symbol)) begin
        local_bad_next = 1'b1;
      end
      previous_dot_next = is_dot;
      if (local_length != LENGTH_MAX) begin
        local_length_next = local_length + 8'd1;
      end
    end else begin
      if (!is_alnum(symbol) && !is_dot && (symbol != CHAR_HYPHEN)) begin
        domain_bad_next = 1'b1;
      end
      previous_hyphen_next = (symbol == CHAR_HYPHEN);
      if (domain_length != LENGTH_MAX) begin
        domain_length_next = domain_length + 8'd1;
      end
    end
  end

  assign verdict = (at_count_next == AT_COUNT_ONE) &&
                   (local_length_next != 8'd0) &&
                   (local_length_next <= limits.local_limit) && !local_bad_next &&
                   (domain_length_next != 8'd0) &&
                   (domain_length_next <= limits.domain_limit) && !domain_bad_next &&
                   !previous_hyphen_next;

  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      past_at         <= 1'b0;
      at_count        <= 2'd0;
      local_length    <= 8'd0;
      domain_length   <= 8'd0;
      previous_dot    <= 1'b0;
      local_bad       <= 1'b0;
      domain_bad      <= 1'b0;
      previous_hyphen <= 1'b0;
    end else if (step) begin
      past_at         <= past_at_next;
      at_count        <= at_count_next;
      local_length    <= local_length_next;
      domain_length   <= domain_length_next;
      previous_dot    <= previous_dot_next;
      local_bad       <= local_bad_next;
      domain_bad      <= domain_bad_next;
      previous_hyphen <= previous_hyphen_next;
    end
  end

endmodule

// ===== rtl/email_address_syntax_check_core.sv =====
// Top level of the address syntax checker: input register, limit registers,
// scan logic (eac_scan) and result register. Depends on eac_pkg.
//
//   channel  signals                                 direction
//   input    in_valid/in_ready, symbol, final_byte   in
//   result   out_valid/out_ready, valid_res          out
//   config   cfg_we, cfg_index, cfg_data             in
//
// One byte is accepted per cycle unless a held verdict stalls a final byte.
// A verdict passes through the input register, where the scan logic works on
// the final byte, into the result register, loaded when that byte advances.
// Reset clears the scan state, empties both registers and restores the limits.
// A held verdict stalls only a final byte; other bytes keep flowing.
module email_address_syntax_check_core import eac_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             symbol,
  input  logic                   final_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   valid_res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  logic        stage_valid;
  logic [7:0]  stage_symbol;
  logic        stage_final;
  logic        advance;
  logic        verdict;
  eac_limits_t limits;

  assign advance  = stage_valid && (!stage_final || !out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.local_limit  <= LOCAL_LIMIT_RESET;
      limits.domain_limit <= DOMAIN_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_LIMIT:  limits.local_limit  <= cfg_data;
        REG_DOMAIN_LIMIT: limits.domain_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_symbol <= symbol;
      stage_final  <= final_byte;
    end
  end

  eac_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .symbol     (stage_symbol),
    .final_byte (stage_final),
    .limits     (limits),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_final) begin
      valid_res <= verdict;
    end
  end

endmodule

// ===== rtl/eac_checker.sv =====
// Port-level checks for the address syntax checker, bound to the top level.
// Depends on the ports of email_address_syntax_check_core only.
module eac_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       final_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       valid_res
);

  // A verdict that is not taken stays in place.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_res))
    else $error("held verdict changed or dropped");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A new verdict follows an accepted final-byte transaction.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && final_byte, 2))
    else $error("verdict without a final byte");

  // With the result side empty, the input side never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind email_address_syntax_check_core eac_checker u_eac_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .final_byte (final_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .valid_res  (valid_res)
);
